>>> rtl/axis_angle_rotation_matrix_defines.svh
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_defines
// Assertion macros for the axis-angle rotation matrix block.
// ----------------------------------------------------------------------------
`ifndef AXIS_ANGLE_ROTATION_MATRIX_DEFINES_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked check, masked while reset is applied
`define AAR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
// clocked check that also holds during reset
`define AAR_ASSERT_NR(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");
`else
`define AAR_ASSERT(lbl, clk, rst_n, prop)
`define AAR_ASSERT_NR(lbl, clk, prop)
`endif

`endif

>>> rtl/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg
// Widths, sine table build and shared types for the rotation matrix block.
// ----------------------------------------------------------------------------
package aarm_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int QUARTER_SIZE    = 1 << SINE_TABLE_BITS;
	localparam int ROM_ADDR_W      = SINE_TABLE_BITS + 1;
	localparam int ROM_DATA_W      = 16;
	localparam int AXIS_W          = 16;
	localparam int ANGLE_W         = 16;
	localparam int ENTRY_W         = 18;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [0:10] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506
	};

	typedef logic [ROM_DATA_W-1:0] rom_t [0:QUARTER_SIZE];

	// quarter-wave sine in Q1.15, Taylor series in Q30, truncating steps
	function automatic rom_t build_sine_rom();
		rom_t                rom;
		logic [63:0]         xq;
		logic [63:0]         x2;
		logic [63:0]         term;
		logic signed [63:0]  sum;
		for (int k = 0; k <= QUARTER_SIZE; k++) begin
			xq   = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
			x2   = (xq * xq) >> 30;
			term = xq;
			sum  = '0;
			for (int n = 0; n < 11; n++) begin
				if (n[0])
					sum = sum - $signed(term);
				else
					sum = sum + $signed(term);
				term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			end
			if (sum < 0)
				sum = '0;
			sum = (sum + 64'sd16384) >>> 15;
			if (sum > 64'sd32768)
				sum = 64'sd32768;
			rom[k] = ROM_DATA_W'(sum);
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_sine_rom();

endpackage

>>> rtl/axis_angle_rotation_matrix.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// 3x3 axis-angle rotation matrix from an unnormalized axis and a turn angle.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  axis     axis_valid/axis_stall   axis_x, axis_y, axis_z, turn_angle
//  m        m_valid/m_stall         m_r0c0 .. m_r2c2
//
//  Three register stages: sine table read with axis pair products, then
//  the t and s products, then sum, round and saturate into the output.
//  One request per cycle while axis_stall is low.
//  Reset clears the stage valid bits only.
//  A stage advances when it is empty or the stage after it advances, so
//  bubbles are squeezed out and axis_stall rises only when all stages are full.
// ----------------------------------------------------------------------------
`include "axis_angle_rotation_matrix_defines.svh"

module axis_angle_rotation_matrix (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 axis_valid,
	output logic                                 axis_stall,
	input  logic signed [aarm_pkg::AXIS_W-1:0]   axis_x,
	input  logic signed [aarm_pkg::AXIS_W-1:0]   axis_y,
	input  logic signed [aarm_pkg::AXIS_W-1:0]   axis_z,
	input  logic [aarm_pkg::ANGLE_W-1:0]         turn_angle,
	output logic                                 m_valid,
	input  logic                                 m_stall,
	output logic signed [aarm_pkg::ENTRY_W-1:0]  m_r0c0,
	output logic signed [aarm_pkg::ENTRY_W-1:0]  m_r0c1,
	output logic signed [aarm_pkg::ENTRY_W-1:0]  m_r0c2,
	output logic signed [aarm_pkg::ENTRY_W-1:0]  m_r1c0,
	output logic signed [aarm_pkg::ENTRY_W-1:0]  m_r1c1,
	output logic signed [aarm_pkg::ENTRY_W-1:0]  m_r1c2,
	output logic signed [aarm_pkg::ENTRY_W-1:0]  m_r2c0,
	output logic signed [aarm_pkg::ENTRY_W-1:0]  m_r2c1,
	output logic signed [aarm_pkg::ENTRY_W-1:0]  m_r2c2
);
	import aarm_pkg::*;

	localparam int PAIR_W = 2 * AXIS_W;
	localparam int TP_W   = 48;
	localparam int SE_W   = AXIS_W + 17;
	localparam int SUM_W  = 49;

	// axis pair products
	localparam int XX = 0;
	localparam int XY = 1;
	localparam int XZ = 2;
	localparam int YY = 3;
	localparam int YZ = 4;
	localparam int ZZ = 5;
	// s times one axis
	localparam int SX = 0;
	localparam int SY = 1;
	localparam int SZ = 2;

	function automatic logic signed [ENTRY_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		r = (v + (SUM_W'(1) <<< 29)) >>> 30;
		if (r > SUM_W'(131071))
			r = SUM_W'(131071);
		else if (r < -SUM_W'(131072))
			r = -SUM_W'(131072);
		return r[ENTRY_W-1:0];
	endfunction

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	assign en3        = !v_s3 || !m_stall;
	assign en2        = !v_s2 || en3;
	assign en1        = !v_s1 || en2;
	assign axis_stall = !en1;
	assign m_valid    = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= axis_valid;
			if (en2)
				v_s2 <= v_s1;
			if (en3)
				v_s3 <= v_s2;
		end
	end

	// stage 1: table read, axis pairs
	logic [ROM_ADDR_W-1:0]      addr_a, addr_b;
	logic [ROM_DATA_W-1:0]      rom_a_s1, rom_b_s1;
	logic [1:0]                 quad_s1;
	logic signed [PAIR_W-1:0]   pair_s1 [6];
	logic signed [AXIS_W-1:0]   x_s1, y_s1, z_s1;

	assign addr_a = {1'b0, turn_angle[13 -: SINE_TABLE_BITS]};
	assign addr_b = ROM_ADDR_W'(QUARTER_SIZE) - addr_a;

	aarm_sine_rom u_rom (
		.clk    (clk),
		.en     (en1),
		.addr_a (addr_a),
		.addr_b (addr_b),
		.data_a (rom_a_s1),
		.data_b (rom_b_s1)
	);

	always_ff @(posedge clk) begin
		if (en1) begin
			quad_s1     <= turn_angle[15:14];
			x_s1        <= axis_x;
			y_s1        <= axis_y;
			z_s1        <= axis_z;
			pair_s1[XX] <= PAIR_W'(axis_x) * PAIR_W'(axis_x);
			pair_s1[XY] <= PAIR_W'(axis_x) * PAIR_W'(axis_y);
			pair_s1[XZ] <= PAIR_W'(axis_x) * PAIR_W'(axis_z);
			pair_s1[YY] <= PAIR_W'(axis_y) * PAIR_W'(axis_y);
			pair_s1[YZ] <= PAIR_W'(axis_y) * PAIR_W'(axis_z);
			pair_s1[ZZ] <= PAIR_W'(axis_z) * PAIR_W'(axis_z);
		end
	end

	// stage 2: s, c, t and products
	logic [ROM_DATA_W-1:0]      s_mag, c_mag;
	logic signed [16:0]         s_val, c_val;
	logic signed [17:0]         t_val;
	logic signed [TP_W-1:0]     tp_full [6];
	logic signed [TP_W-1:0]     tp_s2 [6];
	logic signed [SE_W-1:0]     se_s2 [3];
	logic signed [16:0]         c_s2;

	always_comb begin
		s_mag = quad_s1[0] ? rom_b_s1 : rom_a_s1;
		c_mag = quad_s1[0] ? rom_a_s1 : rom_b_s1;
		s_val = quad_s1[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
		c_val = (quad_s1[1] ^ quad_s1[0]) ? -$signed({1'b0, c_mag})
		                                  : $signed({1'b0, c_mag});
		t_val = 18'sd32768 - 18'(c_val);
		for (int k = 0; k < 6; k++)
			tp_full[k] = TP_W'(t_val) * TP_W'(pair_s1[k]);
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int k = 0; k < 6; k++)
				tp_s2[k] <= tp_full[k];
			se_s2[SX] <= SE_W'(s_val) * SE_W'(x_s1);
			se_s2[SY] <= SE_W'(s_val) * SE_W'(y_s1);
			se_s2[SZ] <= SE_W'(s_val) * SE_W'(z_s1);
			c_s2      <= c_val;
		end
	end

	// stage 3: sum, round, saturate
	logic signed [SUM_W-1:0]    tpe [6];
	logic signed [SUM_W-1:0]    sh [3];
	logic signed [SUM_W-1:0]    cc;
	logic signed [ENTRY_W-1:0]  ent_s3 [9];

	always_comb begin
		for (int k = 0; k < 6; k++)
			tpe[k] = SUM_W'(tp_s2[k]);
		for (int k = 0; k < 3; k++)
			sh[k] = SUM_W'(se_s2[k]) <<< 15;
		cc = SUM_W'(c_s2) <<< 30;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			ent_s3[0] <= round_sat(tpe[XX] + cc);
			ent_s3[1] <= round_sat(tpe[XY] + sh[SZ]);
			ent_s3[2] <= round_sat(tpe[XZ] - sh[SY]);
			ent_s3[3] <= round_sat(tpe[XY] - sh[SZ]);
			ent_s3[4] <= round_sat(tpe[YY] + cc);
			ent_s3[5] <= round_sat(tpe[YZ] + sh[SX]);
			ent_s3[6] <= round_sat(tpe[XZ] + sh[SY]);
			ent_s3[7] <= round_sat(tpe[YZ] - sh[SX]);
			ent_s3[8] <= round_sat(tpe[ZZ] + cc);
		end
	end

	assign m_r0c0 = ent_s3[0];
	assign m_r0c1 = ent_s3[1];
	assign m_r0c2 = ent_s3[2];
	assign m_r1c0 = ent_s3[3];
	assign m_r1c1 = ent_s3[4];
	assign m_r1c2 = ent_s3[5];
	assign m_r2c0 = ent_s3[6];
	assign m_r2c1 = ent_s3[7];
	assign m_r2c2 = ent_s3[8];

	`AAR_ASSERT_NR(a_rst_empty, clk, !arst_n |-> !m_valid)
	`AAR_ASSERT(a_stall_full, clk, arst_n, axis_stall |-> v_s1 && v_s2 && v_s3 && m_stall)
	`AAR_ASSERT(a_accept_s1, clk, arst_n, axis_valid && !axis_stall |=> v_s1)
	`AAR_ASSERT(a_s2_held, clk, arst_n, v_s2 && v_s3 && m_stall |=> v_s2)
	`AAR_ASSERT(a_s2_moves, clk, arst_n, v_s2 && !m_stall |=> v_s3)

endmodule

>>> rtl/aarm_sine_rom.sv
// ----------------------------------------------------------------------------
// aarm_sine_rom
// Quarter-wave sine table with two registered read ports.
// ----------------------------------------------------------------------------
module aarm_sine_rom (
	input  logic                             clk,
	input  logic                             en,
	input  logic [aarm_pkg::ROM_ADDR_W-1:0]  addr_a,
	input  logic [aarm_pkg::ROM_ADDR_W-1:0]  addr_b,
	output logic [aarm_pkg::ROM_DATA_W-1:0]  data_a,
	output logic [aarm_pkg::ROM_DATA_W-1:0]  data_b
);
	import aarm_pkg::*;

	logic [ROM_DATA_W-1:0] rd_a_s1;
	logic [ROM_DATA_W-1:0] rd_b_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			rd_a_s1 <= SINE_ROM[addr_a];
			rd_b_s1 <= SINE_ROM[addr_b];
		end
	end

	assign data_a = rd_a_s1;
	assign data_b = rd_b_s1;

endmodule

>>> tb/axis_angle_rotation_matrix_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_test
// Drives axis/angle requests through the rotation matrix block with bursty
// input and a patterned output stall, including one long output hold-off
// that backs the pipeline up. Each result is checked entry by entry against
// a predictor built on its own quarter-wave sine table.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_test;
	import aarm_pkg::*;

	localparam int  RANDOM_REQS = 500;
	localparam int  CYCLE_LIMIT = 200000;
	localparam int  HOLD_START  = 250;
	localparam int  HOLD_LEN    = 80;
	localparam longint ENTRY_MAX = 131071;
	localparam longint ENTRY_MIN = -131072;

	typedef struct packed {
		logic signed [AXIS_W-1:0] x;
		logic signed [AXIS_W-1:0] y;
		logic signed [AXIS_W-1:0] z;
		logic [ANGLE_W-1:0]       angle;
	} axis_req_t;

	typedef logic [8:0][ENTRY_W-1:0] matrix_t;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b1;
	logic                        axis_valid = 1'b0;
	logic                        axis_stall;
	logic signed [AXIS_W-1:0]    axis_x = '0;
	logic signed [AXIS_W-1:0]    axis_y = '0;
	logic signed [AXIS_W-1:0]    axis_z = '0;
	logic [ANGLE_W-1:0]          turn_angle = '0;
	logic                        m_valid;
	logic                        m_stall = 1'b0;
	logic signed [ENTRY_W-1:0]   m_r0c0, m_r0c1, m_r0c2;
	logic signed [ENTRY_W-1:0]   m_r1c0, m_r1c1, m_r1c2;
	logic signed [ENTRY_W-1:0]   m_r2c0, m_r2c1, m_r2c2;

	int unsigned  sin_tab [0:QUARTER_SIZE];
	axis_req_t    pending_reqs [$];
	matrix_t      expected_mats [$];
	string        entry_name [9] = '{"r0c0", "r0c1", "r0c2", "r1c0", "r1c1",
		"r1c2", "r2c0", "r2c1", "r2c2"};

	logic         req_taken = 1'b0;
	int           errors = 0;
	int           cycles = 0;
	int           burst_left = 0;
	int           gap_left = 0;
	int           rx_cycles = 0;
	int           hold_left = 0;
	int           phase_left = 0;
	rx_mode_t     rx_mode = RX_FREE;
	matrix_t      got_mat, want_mat;

	axis_angle_rotation_matrix dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.axis_valid (axis_valid),
		.axis_stall (axis_stall),
		.axis_x     (axis_x),
		.axis_y     (axis_y),
		.axis_z     (axis_z),
		.turn_angle (turn_angle),
		.m_valid    (m_valid),
		.m_stall    (m_stall),
		.m_r0c0     (m_r0c0),
		.m_r0c1     (m_r0c1),
		.m_r0c2     (m_r0c2),
		.m_r1c0     (m_r1c0),
		.m_r1c1     (m_r1c1),
		.m_r1c2     (m_r1c2),
		.m_r2c0     (m_r2c0),
		.m_r2c1     (m_r2c1),
		.m_r2c2     (m_r2c2)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Taylor series in Q30 with truncating steps, rounded half up to Q15
	function automatic void fill_sine_table();
		bit [63:0] xq;
		bit [63:0] x2;
		bit [63:0] term;
		longint    acc;
		for (int k = 0; k <= QUARTER_SIZE; k++) begin
			xq   = (64'd1686629713 * 64'(k)) >> SINE_TABLE_BITS;
			x2   = (xq * xq) >> 30;
			term = xq;
			acc  = 0;
			for (int n = 0; n < 11; n++) begin
				acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
				term = ((term * x2) >> 30) / 64'((2 * n + 2) * (2 * n + 3));
			end
			if (acc < 0)
				acc = 0;
			acc = (acc + 16384) >>> 15;
			if (acc > 32768)
				acc = 32768;
			sin_tab[k] = int'(acc);
		end
	endfunction

	function automatic longint sine_q15(logic [ANGLE_W-1:0] a);
		logic [1:0]  quad;
		int unsigned idx;
		longint      v;
		quad = a[15:14];
		idx  = int'(a[13:0]) >> (14 - SINE_TABLE_BITS);
		v    = quad[0] ? longint'(sin_tab[QUARTER_SIZE - idx]) : longint'(sin_tab[idx]);
		return quad[1] ? -v : v;
	endfunction

	function automatic logic [ENTRY_W-1:0] q45_to_entry(longint q45);
		longint r;
		r = (q45 + 64'sd536870912) >>> 30;
		if (r > ENTRY_MAX)
			r = ENTRY_MAX;
		if (r < ENTRY_MIN)
			r = ENTRY_MIN;
		return r[ENTRY_W-1:0];
	endfunction

	function automatic matrix_t rotation_of(axis_req_t r);
		longint  x, y, z, s, c, t, sx, sy, sz, cc;
		matrix_t m;
		x  = longint'($signed(r.x));
		y  = longint'($signed(r.y));
		z  = longint'($signed(r.z));
		s  = sine_q15(r.angle);
		c  = sine_q15(r.angle + 16'h4000);
		t  = 32768 - c;
		sx = s * x * 32768;
		sy = s * y * 32768;
		sz = s * z * 32768;
		cc = c * 64'sd1073741824;
		m[0] = q45_to_entry(t * x * x + cc);
		m[1] = q45_to_entry(t * x * y + sz);
		m[2] = q45_to_entry(t * x * z - sy);
		m[3] = q45_to_entry(t * y * x - sz);
		m[4] = q45_to_entry(t * y * y + cc);
		m[5] = q45_to_entry(t * y * z + sx);
		m[6] = q45_to_entry(t * z * x + sy);
		m[7] = q45_to_entry(t * z * y - sx);
		m[8] = q45_to_entry(t * z * z + cc);
		return m;
	endfunction

	// mostly uniform, sometimes an extreme value
	function automatic logic [AXIS_W-1:0] pick_axis();
		logic [AXIS_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = 16'h8000;
			1: v = 16'h7FFF;
			2: v = 16'h0000;
			3: v = 16'hFFFF;
			default: v = AXIS_W'($urandom_range(0, 65535));
		endcase
		return v;
	endfunction

	function automatic logic [ANGLE_W-1:0] pick_angle();
		logic [ANGLE_W-1:0] v;
		v = ANGLE_W'($urandom_range(0, 65535));
		if ($urandom_range(0, 7) == 0)
			v = {v[15:14], ($urandom_range(0, 1) == 1) ? 14'h3FFF : 14'h0000};
		return v;
	endfunction

	task automatic add_req(int x, int y, int z, int angle);
		axis_req_t r;
		r.x     = x[AXIS_W-1:0];
		r.y     = y[AXIS_W-1:0];
		r.z     = z[AXIS_W-1:0];
		r.angle = angle[ANGLE_W-1:0];
		pending_reqs.push_back(r);
	endtask

	initial begin
		axis_req_t r;
		fill_sine_table();

		// directed: zero axis, unit axes, full-scale axes, quadrant edges,
		// angles below one table step and just around each quarter
		add_req(0, 0, 0, 0);
		add_req(32767, 0, 0, 16384);
		add_req(0, 32767, 0, 32768);
		add_req(0, 0, 32767, 49152);
		add_req(-32768, -32768, -32768, 32768);
		add_req(32767, 32767, 32767, 49152);
		add_req(-32768, 32767, -32768, 65535);
		add_req(32767, -32768, 32767, 1);
		add_req(-32768, -32768, 32767, 15);
		add_req(23170, 23170, 0, 16);
		add_req(18919, -18919, 18919, 16383);
		add_req(-32768, 0, 32767, 16385);
		add_req(32767, 32767, -32768, 8192);
		add_req(-1, -1, -1, 24576);
		add_req(1, -1, 1, 40960);
		add_req(-32768, -32768, -32768, 57344);
		add_req(32767, 32767, 32767, 32767);
		add_req(-32768, 32767, 32767, 49151);
		add_req(32767, -32768, -32768, 65520);
		add_req(0, -32768, 0, 65535);

		for (int i = 0; i < RANDOM_REQS; i++) begin
			r.x     = pick_axis();
			r.y     = pick_axis();
			r.z     = pick_axis();
			r.angle = pick_angle();
			pending_reqs.push_back(r);
		end

		#1 arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || axis_valid || expected_mats.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// request driver: bursts of random length, random gaps
	always @(negedge clk) begin
		if (arst_n && (!axis_valid || req_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				axis_valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				{axis_x, axis_y, axis_z, turn_angle} <= pending_reqs.pop_front();
				axis_valid <= 1'b1;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 60);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				axis_valid <= 1'b0;
			end
		end
	end

	// result stall: phases of random pattern, one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			rx_cycles++;
			if (rx_cycles == HOLD_START)
				hold_left = HOLD_LEN;
			if (hold_left > 0) begin
				hold_left--;
				m_stall <= 1'b1;
			end else begin
				if (phase_left == 0) begin
					rx_mode    = rx_mode_t'($urandom_range(0, 3));
					phase_left = $urandom_range(20, 150);
				end
				phase_left--;
				case (rx_mode)
					RX_FREE:  m_stall <= 1'b0;
					RX_LIGHT: m_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY: m_stall <= ($urandom_range(0, 3) != 0);
					default:  m_stall <= (rx_cycles % 5 < 2);
				endcase
			end
		end
	end

	// monitor: predict on accepted request, check on accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= axis_valid && !axis_stall;
			if (axis_valid && !axis_stall)
				expected_mats.push_back(rotation_of({axis_x, axis_y, axis_z, turn_angle}));
			if (m_valid && !m_stall) begin
				got_mat = {m_r2c2, m_r2c1, m_r2c0, m_r1c2, m_r1c1, m_r1c0,
					m_r0c2, m_r0c1, m_r0c0};
				if (expected_mats.size() == 0) begin
					$display("%0t: result with no request pending", $time);
					errors++;
				end else begin
					want_mat = expected_mats.pop_front();
					for (int i = 0; i < 9; i++) begin
						if (got_mat[i] !== want_mat[i]) begin
							$display("%0t: m_%s expected %0d got %0d", $time, entry_name[i],
								$signed(want_mat[i]), $signed(got_mat[i]));
							errors++;
						end
					end
				end
			end
		end else begin
			req_taken <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

endmodule

>>> files.f
+incdir+rtl
rtl/aarm_pkg.sv
rtl/aarm_sine_rom.sv
rtl/axis_angle_rotation_matrix.sv
tb/axis_angle_rotation_matrix_test.sv
